// ----- hw/rtl/ptw_pkg.sv -----
// Shared types and constants for the page table walker.
package ptw_pkg;

    localparam int ADDR_W  = 52;
    localparam int VIRT_W  = 48;
    localparam int ENTRY_W = 64;
    localparam int OFF_W   = 21;
    localparam int IDX_W   = 9;

    localparam logic [ADDR_W-1:0] PAGE4K_LOW = 52'hFFF;
    localparam logic [ADDR_W-1:0] PAGE2M_LOW = 52'h1FFFFF;

    localparam int ENTRY_PRESENT_BIT = 0;
    localparam int ENTRY_HUGE_BIT    = 7;

    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_ENTRY     = 1'b1;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef logic [2:0] t_level;

    localparam t_level LVL_IDLE = 3'd0;
    localparam t_level LVL_PML4 = 3'd1;
    localparam t_level LVL_PDPT = 3'd2;
    localparam t_level LVL_PD   = 3'd3;
    localparam t_level LVL_PT   = 3'd4;

    typedef struct packed {
        logic              kind;
        logic              found;
        logic [ADDR_W-1:0] base;
        logic [OFF_W-1:0]  off;
    } t_walk_op;

endpackage

// ----- hw/rtl/ptw_if.sv -----
// Channel interfaces: request input, result output, configuration write.
interface ptw_in_if import ptw_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               op;
    logic [VIRT_W-1:0]  virt_addr;
    logic [ENTRY_W-1:0] read_data;

    modport source (output valid, output op, output virt_addr, output read_data, input ready);
    modport sink   (input valid, input op, input virt_addr, input read_data, output ready);
endinterface

interface ptw_out_if import ptw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [ADDR_W-1:0] mem_addr;
    logic [ADDR_W-1:0] phys_addr;
    logic              found;

    modport source (output valid, output kind, output mem_addr, output phys_addr,
                    output found, input ready);
    modport sink   (input valid, input kind, input mem_addr, input phys_addr,
                    input found, output ready);
endinterface

interface ptw_cfg_if import ptw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/ptw_front.sv -----
// Front end: accepts transactions, tracks the walk level and classifies entries.
module ptw_front import ptw_pkg::*; #(
    parameter int PHYS_ADDR_BITS = 52
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ptw_in_if.sink        i_req,
    ptw_cfg_if.sink       i_cfg,
    input  logic          i_q_full,
    output logic          o_push,
    output t_walk_op      o_push_op
);

    localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - PHYS_ADDR_BITS);
    localparam logic [ADDR_W-1:0] FRAME4K_MASK = ADDR_MASK & ~PAGE4K_LOW;
    localparam logic [ADDR_W-1:0] FRAME2M_MASK = ADDR_MASK & ~PAGE2M_LOW;

    t_level              r_level, n_level;
    logic [VIRT_W-1:0]   r_saved_virt, n_saved_virt;
    logic [ADDR_W-1:0]   r_table_base;

    logic                accept;
    logic                busy;
    logic [ADDR_W-1:0]   entry_addr;
    logic [IDX_W-1:0]    next_idx;

    assign i_req.ready = !i_q_full;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_req.valid && i_req.ready;
    assign busy        = (r_level >= LVL_PML4) && (r_level <= LVL_PT);
    assign entry_addr  = i_req.read_data[ADDR_W-1:0];

    always_comb begin
        case (r_level)
            LVL_PML4: next_idx = r_saved_virt[38:30];
            LVL_PDPT: next_idx = r_saved_virt[29:21];
            default:  next_idx = r_saved_virt[20:12];
        endcase
    end

    always_comb begin
        n_level      = r_level;
        n_saved_virt = r_saved_virt;
        o_push       = 1'b0;
        o_push_op    = '{kind: KIND_READ, found: 1'b0, base: '0, off: '0};
        if (accept) begin
            if (i_req.op == OP_TRANSLATE) begin
                if (!busy) begin
                    n_saved_virt   = i_req.virt_addr;
                    n_level        = LVL_PML4;
                    o_push         = 1'b1;
                    o_push_op.base = r_table_base & FRAME4K_MASK;
                    o_push_op.off  = {{(OFF_W-IDX_W-3){1'b0}}, i_req.virt_addr[47:39], 3'b000};
                end
            end else if (busy) begin
                o_push = 1'b1;
                if (!i_req.read_data[ENTRY_PRESENT_BIT]) begin
                    n_level        = LVL_IDLE;
                    o_push_op.kind = KIND_DONE;
                end else if (r_level == LVL_PD && i_req.read_data[ENTRY_HUGE_BIT]) begin
                    n_level         = LVL_IDLE;
                    o_push_op.kind  = KIND_DONE;
                    o_push_op.found = 1'b1;
                    o_push_op.base  = entry_addr & FRAME2M_MASK;
                    o_push_op.off   = r_saved_virt[OFF_W-1:0];
                end else if (r_level == LVL_PT) begin
                    n_level         = LVL_IDLE;
                    o_push_op.kind  = KIND_DONE;
                    o_push_op.found = 1'b1;
                    o_push_op.base  = entry_addr & FRAME4K_MASK;
                    o_push_op.off   = {{(OFF_W-12){1'b0}}, r_saved_virt[11:0]};
                end else begin
                    n_level        = r_level + 3'd1;
                    o_push_op.base = entry_addr & FRAME4K_MASK;
                    o_push_op.off  = {{(OFF_W-IDX_W-3){1'b0}}, next_idx, 3'b000};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level      <= LVL_IDLE;
            r_saved_virt <= '0;
            r_table_base <= '0;
        end else begin
            r_level      <= n_level;
            r_saved_virt <= n_saved_virt;
            if (i_cfg.valid && i_cfg.ready) begin
                r_table_base <= i_cfg.data;
            end
        end
    end

`ifndef SYNTH
    a_start_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_req.op == OP_TRANSLATE && !busy |=> r_level == LVL_PML4)
        else $error("walk did not start at the root level");

    a_idle_resp_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_req.op == OP_ENTRY && !busy |-> !o_push)
        else $error("response while idle produced a result");

    a_walk_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy && !accept |=> $stable(r_level) && $stable(r_saved_virt))
        else $error("walk state changed without a transaction");
`endif

endmodule

// ----- hw/rtl/ptw_queue.sv -----
// Short queue of classified walk steps between front and back.
module ptw_queue import ptw_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_walk_op i_push_op,
    input  logic     i_pop,
    output logic     o_full,
    output logic     o_empty,
    output t_walk_op o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_walk_op        r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            r_count <= r_count + CW'(do_push) - CW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_op;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");
`endif

endmodule

// ----- hw/rtl/ptw_back.sv -----
// Back end: forms the entry or physical address and holds the result register.
module ptw_back import ptw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_walk_op   i_head,
    output logic       o_pop,
    ptw_out_if.source  o_rsp
);

    logic              r_valid;
    logic              r_kind, r_found;
    logic [ADDR_W-1:0] r_mem_addr, r_phys_addr;
    logic              load;
    logic [ADDR_W-1:0] sum;

    assign load  = !r_valid || o_rsp.ready;
    assign o_pop = load && !i_q_empty;
    assign sum   = i_head.base + {{(ADDR_W-OFF_W){1'b0}}, i_head.off};

    assign o_rsp.valid     = r_valid;
    assign o_rsp.kind      = r_kind;
    assign o_rsp.found     = r_found;
    assign o_rsp.mem_addr  = r_mem_addr;
    assign o_rsp.phys_addr = r_phys_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= !i_q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind      <= i_head.kind;
            r_found     <= i_head.found;
            r_mem_addr  <= (i_head.kind == KIND_READ) ? sum : '0;
            r_phys_addr <= (i_head.kind == KIND_DONE) ? sum : '0;
        end
    end

`ifndef SYNTH
    a_read_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_kind == KIND_READ |-> r_phys_addr == '0 && !r_found)
        else $error("read request carries translation fields");
`endif

endmodule

// ----- hw/rtl/page_table_walker_core.sv -----
// Top level of the four-level page table walker.
//
//  channel   dir  transaction
//  i_req     in   op, virt_addr, read_data (translate request or table entry)
//  o_rsp     out  kind, mem_addr, phys_addr, found (read request or translation)
//  i_cfg     in   data = table_base
//
//  One transaction per cycle is accepted while the queue is not full; any result
//  of a transaction is written into a queue entry at the accepting edge, and the
//  output register loads it from the queue head when o_rsp is not stalled.
//  The front stalls only when the queue of QUEUE_DEPTH entries is full.
//  Reset is synchronous: walk idle, table_base zero, queue and output empty.
//  A stalled o_rsp holds its result while the queue keeps filling.
module page_table_walker_core import ptw_pkg::*; #(
    parameter int PHYS_ADDR_BITS = 52,
    parameter int QUEUE_DEPTH    = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ptw_in_if.sink     i_req,
    ptw_cfg_if.sink    i_cfg,
    ptw_out_if.source  o_rsp
);

    logic     push, pop, q_full, q_empty;
    t_walk_op push_op, head;

    ptw_front #(
        .PHYS_ADDR_BITS(PHYS_ADDR_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_cfg     (i_cfg),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_push_op (push_op)
    );

    ptw_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_op (push_op),
        .i_pop     (pop),
        .o_full    (q_full),
        .o_empty   (q_empty),
        .o_head    (head)
    );

    ptw_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_head    (head),
        .o_pop     (pop),
        .o_rsp     (o_rsp)
    );

endmodule
